FILE: hdl/wsd_pkg.sv
// Package: shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  localparam int unsigned LenWidthDef = 64;
  localparam logic [15:0] MinInnerRst = 16'd10;
  localparam logic [15:0] MaxInnerRst = 16'd65534;
  localparam int unsigned QueueDepth = 4;

  localparam logic [0:0] CfgMinIdx = 1'd0;
  localparam logic [0:0] CfgMaxIdx = 1'd1;

  localparam logic [3:0] OpText = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  typedef enum logic [4:0] {
    PH_HDR1    = 5'b00001,
    PH_HDR2    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // Classified payload byte passed from the parser to the delivery stage.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       deliver;
    logic       ends;
  } pay_item_t;

endpackage

FILE: hdl/wsd_stream_if.sv
// Interface: valid/ready channel carrying one item.
interface wsd_stream_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/wsd_parser.sv
// Front end: header parsing and payload unmasking.
module wsd_parser #(
  parameter int unsigned LEN_WIDTH = wsd_pkg::LenWidthDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  output logic              pay_valid,
  input  logic              pay_ready,
  output wsd_pkg::pay_item_t pay_item
);

  wsd_pkg::phase_t       phase_r, phase_nxt;
  logic [3:0]            opcode_r, opcode_nxt;
  logic                  masked_r, masked_nxt;
  logic                  deliver_r, deliver_nxt;
  logic [LEN_WIDTH-1:0]  remain_r, remain_nxt;
  logic                  sat_r, sat_nxt;
  logic [3:0]            cnt_r, cnt_nxt;
  logic [31:0]           key_r, key_nxt;
  logic [1:0]            idx_r, idx_nxt;
  logic                  first_r, first_nxt;
  logic                  acc;
  logic [6:0]            len7;
  logic [7:0]            kbyte;
  logic [LEN_WIDTH-1:0]  shifted;
  logic                  ovf;

  // Stall only when a payload byte cannot be queued.
  assign in_ready = (phase_r != wsd_pkg::PH_PAYLOAD) || pay_ready;
  assign acc = in_valid && in_ready;
  assign len7 = rx_byte[6:0];

  always_comb begin
    unique case (idx_r)
      2'd0: kbyte = key_r[31:24];
      2'd1: kbyte = key_r[23:16];
      2'd2: kbyte = key_r[15:8];
      default: kbyte = key_r[7:0];
    endcase
  end

  assign pay_valid = in_valid && (phase_r == wsd_pkg::PH_PAYLOAD);
  assign pay_item.data = masked_r ? (rx_byte ^ kbyte) : rx_byte;
  assign pay_item.first = first_r;
  assign pay_item.deliver = deliver_r;
  assign pay_item.ends = (remain_r <= LEN_WIDTH'(1));

  assign shifted = {remain_r[LEN_WIDTH-9:0], rx_byte};
  assign ovf = (remain_r[LEN_WIDTH-1 -: 8] != 8'd0);

  always_comb begin
    phase_nxt = phase_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    deliver_nxt = deliver_r;
    remain_nxt = remain_r;
    sat_nxt = sat_r;
    cnt_nxt = cnt_r;
    key_nxt = key_r;
    idx_nxt = idx_r;
    first_nxt = first_r;
    if (acc) begin
      unique case (phase_r)
        wsd_pkg::PH_HDR2: begin
          masked_nxt = rx_byte[7];
          idx_nxt = 2'd0;
          first_nxt = 1'b1;
          sat_nxt = 1'b0;
          if (len7 == wsd_pkg::Len16Code || len7 == wsd_pkg::Len64Code) begin
            deliver_nxt = 1'b1;
            remain_nxt = '0;
            cnt_nxt = (len7 == wsd_pkg::Len16Code) ? 4'd2 : 4'd8;
            phase_nxt = wsd_pkg::PH_EXTLEN;
          end else begin
            deliver_nxt = (opcode_r == wsd_pkg::OpText) || (opcode_r == wsd_pkg::OpBinary);
            remain_nxt = LEN_WIDTH'(len7);
            if (rx_byte[7]) begin
              phase_nxt = wsd_pkg::PH_MASK;
              cnt_nxt = 4'd4;
              key_nxt = '0;
            end else if (len7 != 7'd0) begin
              phase_nxt = wsd_pkg::PH_PAYLOAD;
            end else begin
              phase_nxt = wsd_pkg::PH_HDR1;
            end
          end
        end
        wsd_pkg::PH_EXTLEN: begin
          cnt_nxt = cnt_r - 4'd1;
          if (ovf || sat_r) begin
            sat_nxt = 1'b1;
            remain_nxt = '1;
          end else begin
            remain_nxt = shifted;
          end
          if (cnt_r == 4'd1) begin
            if (masked_r) begin
              phase_nxt = wsd_pkg::PH_MASK;
              cnt_nxt = 4'd4;
              key_nxt = '0;
            end else if (remain_nxt != '0) begin
              phase_nxt = wsd_pkg::PH_PAYLOAD;
            end else begin
              phase_nxt = wsd_pkg::PH_HDR1;
            end
          end
        end
        wsd_pkg::PH_MASK: begin
          key_nxt = {key_r[23:0], rx_byte};
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_r == 4'd1) begin
            phase_nxt = (remain_r != '0) ? wsd_pkg::PH_PAYLOAD : wsd_pkg::PH_HDR1;
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          idx_nxt = idx_r + 2'd1;
          first_nxt = 1'b0;
          if (remain_r <= LEN_WIDTH'(1)) begin
            remain_nxt = '0;
            phase_nxt = wsd_pkg::PH_HDR1;
          end else begin
            remain_nxt = remain_r - LEN_WIDTH'(1);
          end
        end
        default: begin
          opcode_nxt = rx_byte[3:0];
          phase_nxt = wsd_pkg::PH_HDR2;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsd_pkg::PH_HDR1;
      opcode_r <= '0;
      masked_r <= 1'b0;
      deliver_r <= 1'b0;
      remain_r <= '0;
      sat_r <= 1'b0;
      cnt_r <= '0;
      key_r <= '0;
      idx_r <= '0;
      first_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      deliver_r <= deliver_nxt;
      remain_r <= remain_nxt;
      sat_r <= sat_nxt;
      cnt_r <= cnt_nxt;
      key_r <= key_nxt;
      idx_r <= idx_nxt;
      first_r <= first_nxt;
    end
  end

  property p_payload_has_len;
    @(posedge clk) disable iff (!rst_n)
      (phase_r == wsd_pkg::PH_PAYLOAD) |-> (remain_r != '0);
  endproperty
  a_payload_has_len: assert property (p_payload_has_len) else $error("payload with zero length");

  property p_ext_cnt;
    @(posedge clk) disable iff (!rst_n)
      (phase_r == wsd_pkg::PH_EXTLEN || phase_r == wsd_pkg::PH_MASK) |-> (cnt_r != 4'd0);
  endproperty
  a_ext_cnt: assert property (p_ext_cnt) else $error("field count exhausted");

  property p_ends_hdr;
    @(posedge clk) disable iff (!rst_n)
      (acc && phase_r == wsd_pkg::PH_PAYLOAD && pay_item.ends) |=> (phase_r == wsd_pkg::PH_HDR1);
  endproperty
  a_ends_hdr: assert property (p_ends_hdr) else $error("frame end missed");

endmodule

FILE: hdl/wsd_queue.sv
// Short FIFO between parser and delivery stage.
module wsd_queue #(
  parameter int unsigned DEPTH = wsd_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  wsd_pkg::pay_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output wsd_pkg::pay_item_t rd_item
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  wsd_pkg::pay_item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push, pop;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  property p_no_over;
    @(posedge clk) disable iff (!rst_n) cnt_r <= (AW+1)'(DEPTH);
  endproperty
  a_no_over: assert property (p_no_over) else $error("queue overflow");

  property p_count;
    @(posedge clk) disable iff (!rst_n)
      (push && !pop) |=> (cnt_r == $past(cnt_r) + (AW+1)'(1));
  endproperty
  a_count: assert property (p_count) else $error("queue count slip");

  property p_empty;
    @(posedge clk) disable iff (!rst_n) (cnt_r == '0) |-> !pop;
  endproperty
  a_empty: assert property (p_empty) else $error("pop from empty queue");

endmodule

FILE: hdl/wsd_deliver.sv
// Back end: inner length check and message byte delivery.
module wsd_deliver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        min_len,
  input  logic [15:0]        max_len,
  input  logic               q_valid,
  output logic               q_ready,
  input  wsd_pkg::pay_item_t q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         msg_byte,
  output logic               msg_last
);
  logic [2:0]  hidx_r;
  logic [31:0] ilen_r;
  logic        ok_r;
  logic [31:0] left_r;
  logic        ovld_r;
  logic [7:0]  obyte_r;
  logic        olast_r;
  logic        take;
  logic [2:0]  hidx;
  logic        ok;
  logic [31:0] full_len;
  logic        inhdr;
  logic        emit;

  assign q_ready = !ovld_r || out_ready;
  assign take = q_valid && q_ready;
  assign hidx = q_item.first ? 3'd0 : hidx_r;
  assign ok = q_item.first ? q_item.deliver : ok_r;
  assign inhdr = (hidx != 3'd4);
  assign full_len = {ilen_r[23:0], q_item.data};
  assign emit = ok && !inhdr && (left_r != '0);

  assign out_valid = ovld_r;
  assign msg_byte = obyte_r;
  assign msg_last = olast_r;

  always_ff @(posedge clk) begin
    if (take && emit) begin
      obyte_r <= q_item.data;
      olast_r <= (left_r == 32'd1) || q_item.ends;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hidx_r <= '0;
      ilen_r <= '0;
      ok_r <= 1'b0;
      left_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (out_ready) begin
        ovld_r <= 1'b0;
      end
      if (take) begin
        ok_r <= ok;
        if (emit) begin
          ovld_r <= 1'b1;
          left_r <= left_r - 32'd1;
        end
        if (inhdr) begin
          hidx_r <= hidx + 3'd1;
          ilen_r <= full_len;
          if (hidx == 3'd3) begin
            left_r <= full_len;
            if (full_len < {16'd0, min_len} || full_len > {16'd0, max_len}) begin
              ok_r <= 1'b0;
            end
          end
        end else begin
          hidx_r <= hidx;
        end
      end
    end
  end

  property p_hold;
    @(posedge clk) disable iff (!rst_n)
      (ovld_r && !out_ready) |=> (ovld_r && $stable(obyte_r));
  endproperty
  a_hold: assert property (p_hold) else $error("output item lost");

  property p_hidx;
    @(posedge clk) disable iff (!rst_n) hidx_r <= 3'd4;
  endproperty
  a_hidx: assert property (p_hidx) else $error("header index overrun");

  property p_emit_ok;
    @(posedge clk) disable iff (!rst_n) (take && emit) |-> ok;
  endproperty
  a_emit_ok: assert property (p_emit_ok) else $error("emit while dropping");

endmodule

FILE: hdl/websocket_frame_deframer.sv
// Top level: WebSocket frame deframer.
// Throughput: one byte per cycle sustained; parser stalls only on a full queue.
// Path: an accepted payload byte reaches out through the queue and then the output register.
// Header, extended length and mask bytes give no result and never stall.
// Synchronous active-low reset: parser back to first header byte, queue empty,
// bounds to 10 and 65534.
module websocket_frame_deframer #(
  parameter int unsigned LEN_WIDTH = wsd_pkg::LenWidthDef,
  parameter int unsigned QUEUE_DEPTH = wsd_pkg::QueueDepth
) (
  input  logic         clk,
  input  logic         rst_n,
  wsd_stream_if.sink   in_ch,
  wsd_stream_if.source out_ch,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_idx,
  input  logic [15:0]  cfg_wdata
);
  logic [15:0] min_r, max_r;
  logic pay_valid, pay_ready, q_valid, q_ready;
  wsd_pkg::pay_item_t pay_item, q_item;
  logic [7:0] mbyte;
  logic mlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= wsd_pkg::MinInnerRst;
      max_r <= wsd_pkg::MaxInnerRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        wsd_pkg::CfgMinIdx: min_r <= cfg_wdata;
        default: max_r <= cfg_wdata;
      endcase
    end
  end

  wsd_parser #(.LEN_WIDTH(LEN_WIDTH)) u_parser (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .rx_byte(in_ch.data),
    .pay_valid, .pay_ready, .pay_item
  );

  wsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(pay_valid), .wr_ready(pay_ready), .wr_item(pay_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  wsd_deliver u_deliver (
    .clk, .rst_n, .min_len(min_r), .max_len(max_r),
    .q_valid, .q_ready, .q_item,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .msg_byte(mbyte), .msg_last(mlast)
  );

  assign out_ch.data = {mbyte, mlast};

endmodule
